FILE: rtl/twtq_pkg.sv
package twtq_pkg;

	typedef enum logic [1:0] {
		REQ_APPEND  = 2'd0,
		REQ_CLEAR   = 2'd1,
		REQ_WINDOW  = 2'd2,
		REQ_NEAREST = 2'd3
	} req_t;

	// one queued command between front and back
	typedef struct packed {
		req_t        req;
		logic [31:0] t_a;    // min_time or query_time
		logic [31:0] t_b;    // max_time
		logic [6:0]  count;  // saturated max_count
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LO_RD,
		ST_LO_CMP,
		ST_HI_RD,
		ST_HI_CMP,
		ST_PLAN,
		ST_EMIT_RD,
		ST_EMIT_OUT,
		ST_NR_RD,
		ST_NR_CMP,
		ST_NR_PICK,
		ST_NONE
	} bk_state_t;

	typedef enum logic [1:0] {
		OFS_IDLE,
		OFS_RUN,
		OFS_DONE
	} ofs_state_t;

endpackage

FILE: rtl/twtq_front.sv
module twtq_front #(
	parameter int DEPTH   = 1024,
	parameter int MAX_OUT = 64,
	parameter int AW      = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          req_type,
	input  logic signed [31:0]  sample_time,
	input  logic [31:0]         sample_value,
	input  logic signed [31:0]  min_time,
	input  logic signed [31:0]  max_time,
	input  logic [6:0]          max_count,
	input  logic signed [31:0]  query_time,
	input  logic [AW:0]         fill,
	input  logic signed [31:0]  newest_time,
	output logic                wr_en,
	output logic                clr_en,
	output logic [31:0]         wr_time,
	output logic [31:0]         wr_value,
	output twtq_pkg::cmd_t      q_data,
	output logic                q_valid,
	input  logic                q_pop,
	input  logic                back_busy
);
	import twtq_pkg::*;

	localparam logic [6:0] MaxK = 7'(MAX_OUT);

	cmd_t slot_q [2];
	logic [1:0] cnt_q;
	logic       rd_q, wr_q;
	logic       acc;
	cmd_t       cin;
	req_t       rq;

	// store updates must wait until no query is in flight
	assign busy   = (cnt_q == 2'd2) ||
		((req_t'(req_type) == REQ_APPEND || req_t'(req_type) == REQ_CLEAR) &&
		(cnt_q != 2'd0 || back_busy));
	assign acc    = start && !busy;
	assign rq     = req_t'(req_type);
	assign wr_en  = acc && rq == REQ_APPEND && fill < (AW+1)'(DEPTH) &&
		(fill == '0 || sample_time >= newest_time);
	assign clr_en = acc && rq == REQ_CLEAR;
	assign wr_time  = sample_time;
	assign wr_value = sample_value;

	always_comb begin
		cin.req   = rq;
		cin.t_a   = (rq == REQ_WINDOW) ? min_time : query_time;
		cin.t_b   = max_time;
		cin.count = (max_count > MaxK) ? MaxK : max_count;
	end

	assign q_valid = cnt_q != 2'd0;
	assign q_data  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (acc && (rq == REQ_WINDOW || rq == REQ_NEAREST)) slot_q[wr_q] <= cin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			logic push;
			push = acc && (rq == REQ_WINDOW || rq == REQ_NEAREST);
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

FILE: rtl/twtq_offset.sv
module twtq_offset #(
	parameter int NW = 11
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  logic [NW+7:0]  num,
	input  logic [7:0]     den,
	output logic           done,
	output logic [NW+7:0]  quot
);
	import twtq_pkg::*;

	localparam int QW = NW + 8;
	localparam int CW = $clog2(QW + 1);

	ofs_state_t st_q, st_d;
	logic [QW-1:0] n_q;
	logic [8:0]    r_q;
	logic [7:0]    d_q;
	logic [CW-1:0] i_q;
	logic [8:0]    trial;

	// restoring division, one quotient bit per cycle
	assign trial = {r_q[7:0], n_q[QW-1]};

	always_comb begin
		st_d = st_q;
		case (st_q)
			OFS_IDLE: if (go) st_d = OFS_RUN;
			OFS_RUN:  if (i_q == CW'(QW - 1)) st_d = OFS_DONE;
			OFS_DONE: st_d = go ? OFS_RUN : OFS_IDLE;
			default:  st_d = OFS_IDLE;
		endcase
	end

	always_comb begin
		done = st_q == OFS_DONE;
		quot = n_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= OFS_IDLE;
		else         st_q <= st_d;
	end

	always_ff @(posedge clk) begin
		if (go && st_q != OFS_RUN) begin
			n_q <= num;
			r_q <= '0;
			d_q <= den;
			i_q <= '0;
		end else if (st_q == OFS_RUN) begin
			i_q <= i_q + 1'b1;
			if (trial >= {1'b0, d_q}) begin
				r_q <= trial - {1'b0, d_q};
				n_q <= {n_q[QW-2:0], 1'b1};
			end else begin
				r_q <= trial;
				n_q <= {n_q[QW-2:0], 1'b0};
			end
		end
	end
endmodule

FILE: rtl/twtq_back.sv
module twtq_back #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic               clr_en,
	input  logic [31:0]        wr_time,
	input  logic [31:0]        wr_value,
	input  twtq_pkg::cmd_t     q_data,
	input  logic               q_valid,
	output logic               q_pop,
	output logic               back_busy,
	output logic [AW:0]        fill,
	output logic signed [31:0] newest_time,
	output logic               done,
	output logic               found,
	output logic signed [31:0] out_time,
	output logic [31:0]        out_value,
	output logic [9:0]         out_position,
	output logic               last
);
	import twtq_pkg::*;

	localparam int NW = AW + 1;
	localparam int QW = NW + 8;

	logic [31:0] mem_t [DEPTH];
	logic [31:0] mem_v [DEPTH];
	logic [31:0] rd_t_q, rd_v_q;
	logic [AW-1:0] raddr;

	logic [AW:0] fill_q;
	logic signed [31:0] newest_q;

	bk_state_t st_q, st_d;
	cmd_t  c_q;
	logic [AW:0] lo_q, hi_q, first_q, end_q, n_q, after_q;
	logic [AW:0] mid, n_now, emit_pos;
	logic [6:0]  k_q, i_q;
	logic        thin_q;
	logic signed [31:0] prev_t_q;
	logic        lo_ok;

	logic        div_go, div_done;
	logic [QW-1:0] div_num, div_quot;
	logic [7:0]  div_den;
	logic [AW:0] ofs_pos;

	logic o_v_q, o_f_q, o_l_q;
	logic [31:0] o_t_q, o_v2_q;
	logic [9:0]  o_p_q;

	// auxiliary captures for emit position and nearest candidates
	logic [AW:0] raddr_hold_q;
	logic [31:0] nr_t_q, nr_v_q, nr_at_q, nr_av_q, prev_v_q;
	logic [AW:0] nr_p_q;
	logic signed [32:0] gap_lo, gap_hi;

	assign fill        = fill_q;
	assign newest_time = newest_q;
	assign mid         = lo_q + ((hi_q - lo_q) >> 1);
	assign n_now       = lo_q - first_q;
	assign emit_pos    = first_q + (AW+1)'(i_q);

	// distances to the neighbours, one bit wider so extreme times cannot wrap
	assign gap_lo = $signed({c_q.t_a[31], c_q.t_a}) - $signed({prev_t_q[31], prev_t_q});
	assign gap_hi = $signed({nr_at_q[31], nr_at_q}) - $signed({c_q.t_a[31], c_q.t_a});

	// compare target: window lower bound, window upper bound or nearest time
	always_comb begin
		logic signed [31:0] tv;
		tv = (st_q == ST_HI_CMP) ? signed'(c_q.t_b) : signed'(c_q.t_a);
		lo_ok = (st_q == ST_HI_CMP) ? (signed'(rd_t_q) <= tv) : (signed'(rd_t_q) < tv);
	end

	always_comb begin
		raddr = mid[AW-1:0];
		case (st_q)
			ST_EMIT_RD: raddr = thin_q ? ofs_pos[AW-1:0] : emit_pos[AW-1:0];
			ST_NR_PICK: raddr = after_q[AW-1:0];
			default:    raddr = mid[AW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_t[fill_q[AW-1:0]] <= wr_time;
			mem_v[fill_q[AW-1:0]] <= wr_value;
		end
		rd_t_q <= mem_t[raddr];
		rd_v_q <= mem_v[raddr];
	end

	// offset = (2*i*(n-1) + k-1) / (2*(k-1))
	assign div_num = QW'(({8'd0, n_q - 1'b1} * QW'(i_q)) << 1) + QW'(k_q - 7'd1);
	assign div_den = {k_q - 7'd1, 1'b0};
	assign div_go  = st_q == ST_EMIT_RD && thin_q && !div_done;
	assign ofs_pos = first_q + div_quot[AW:0];

	twtq_offset #(.NW(NW)) u_ofs (
		.clk(clk), .arst_n(arst_n), .go(div_go), .num(div_num), .den(div_den),
		.done(div_done), .quot(div_quot)
	);

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (q_valid) begin
				if (q_data.req == REQ_WINDOW) begin
					if (q_data.count == '0 || signed'(q_data.t_a) > signed'(q_data.t_b))
						st_d = ST_NONE;
					else st_d = ST_LO_RD;
				end else st_d = (fill_q == '0) ? ST_NONE : ST_NR_RD;
			end
			ST_LO_RD:  st_d = (lo_q < hi_q) ? ST_LO_CMP : ST_HI_RD;
			ST_LO_CMP: st_d = ST_LO_RD;
			ST_HI_RD:  st_d = (lo_q < hi_q) ? ST_HI_CMP : ST_PLAN;
			ST_HI_CMP: st_d = ST_HI_RD;
			ST_PLAN:   st_d = (lo_q == first_q) ? ST_NONE : ST_EMIT_RD;
			ST_EMIT_RD: if (!thin_q || div_done) st_d = ST_EMIT_OUT;
			ST_EMIT_OUT: st_d = (i_q + 7'd1 == k_q) ? ST_IDLE : ST_EMIT_RD;
			ST_NR_RD:  st_d = (lo_q < hi_q) ? ST_NR_CMP : ST_NR_PICK;
			ST_NR_CMP: st_d = ST_NR_RD;
			ST_NR_PICK: st_d = ST_IDLE;
			ST_NONE:   st_d = ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = st_q == ST_IDLE && q_valid;
		back_busy = st_q != ST_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			fill_q <= '0;
			o_v_q  <= 1'b0;
		end else begin
			st_q  <= st_d;
			o_v_q <= 1'b0;
			if (clr_en) fill_q <= '0;
			else if (wr_en) fill_q <= fill_q + 1'b1;
			case (st_q)
				ST_NONE, ST_EMIT_OUT: o_v_q <= 1'b1;
				ST_NR_PICK: o_v_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) newest_q <= signed'(wr_time);
		case (st_q)
			ST_IDLE: begin
				c_q  <= q_data;
				lo_q <= '0;
				hi_q <= fill_q;
				i_q  <= '0;
			end
			ST_LO_CMP, ST_HI_CMP, ST_NR_CMP: begin
				if (lo_ok) lo_q <= mid + 1'b1;
				else       hi_q <= mid;
				if (st_q == ST_NR_CMP && lo_ok) prev_t_q <= rd_t_q;
			end
			ST_HI_RD: if (!(lo_q < hi_q)) begin
				end_q <= lo_q;
				n_q   <= n_now;
				thin_q <= 32'(n_now) > 32'(c_q.count) && c_q.count != 7'd1;
				k_q   <= (32'(n_now) > 32'(c_q.count)) ? c_q.count : 7'(n_now);
			end
			ST_LO_RD: if (!(lo_q < hi_q)) begin
				first_q <= lo_q;
				hi_q    <= fill_q;
			end
			ST_NR_RD: if (!(lo_q < hi_q)) after_q <= lo_q;
			default: ;
		endcase
		if (st_q == ST_PLAN) lo_q <= end_q;
		if (st_q == ST_HI_RD && !(lo_q < hi_q)) lo_q <= lo_q;
		if (st_q == ST_EMIT_OUT) i_q <= i_q + 7'd1;

		o_f_q  <= 1'b0;
		o_t_q  <= '0;
		o_v2_q <= '0;
		o_p_q  <= '0;
		o_l_q  <= 1'b1;
		if (st_q == ST_EMIT_OUT) begin
			o_f_q  <= 1'b1;
			o_t_q  <= rd_t_q;
			o_v2_q <= rd_v_q;
			o_p_q  <= 10'(raddr_hold_q);
			o_l_q  <= i_q + 7'd1 == k_q;
		end else if (st_q == ST_NR_PICK) begin
			o_f_q <= 1'b1;
			if (after_q == '0 || after_q >= fill_q) begin
				// before first or after last: one read already holds it
				o_t_q  <= nr_t_q;
				o_v2_q <= nr_v_q;
				o_p_q  <= 10'(nr_p_q);
			end else if (gap_lo <= gap_hi) begin
				o_t_q  <= prev_t_q;
				o_v2_q <= prev_v_q;
				o_p_q  <= 10'(after_q - 1'b1);
			end else begin
				o_t_q  <= nr_at_q;
				o_v2_q <= nr_av_q;
				o_p_q  <= 10'(after_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_EMIT_RD) raddr_hold_q <= {1'b0, raddr};
		if (st_q == ST_NR_CMP && lo_ok) prev_v_q <= rd_v_q;
		if (st_q == ST_NR_CMP && !lo_ok) begin
			nr_at_q <= rd_t_q;
			nr_av_q <= rd_v_q;
		end
		if (st_q == ST_NR_CMP) begin
			nr_t_q <= rd_t_q;
			nr_v_q <= rd_v_q;
			nr_p_q <= mid;
		end
	end

	assign done         = o_v_q;
	assign found        = o_f_q;
	assign out_time     = signed'(o_t_q);
	assign out_value    = o_v2_q;
	assign out_position = o_p_q;
	assign last         = o_l_q;
endmodule

FILE: rtl/time_window_trace_query_core.sv
// channel | handshake          | payload
// request | start / busy       | req_type sample_time sample_value min_time max_time
//         |                    | max_count query_time
// result  | done (one cycle)   | found out_time out_value out_position last
// Appends and clears are accepted once queries have drained. A window query runs two
// binary searches over the store (a nearest query runs one), each probe a read, then a
// compare, then emits its results one at a time, each waiting on the serial offset
// divider when thinning. Reset empties the store at once.
// The receiver cannot stall; a two-entry queue lets requests queue behind a query.
module time_window_trace_query_core #(
	parameter int DEPTH   = 1024,
	parameter int MAX_OUT = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] sample_time,
	input  logic [31:0]        sample_value,
	input  logic signed [31:0] min_time,
	input  logic signed [31:0] max_time,
	input  logic [6:0]         max_count,
	input  logic signed [31:0] query_time,
	output logic               done,
	output logic               found,
	output logic signed [31:0] out_time,
	output logic [31:0]        out_value,
	output logic [9:0]         out_position,
	output logic               last
);
	import twtq_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [AW:0] fill;
	logic signed [31:0] newest_time;
	logic wr_en, clr_en, q_valid, q_pop, back_busy;
	logic [31:0] wr_time, wr_value;
	cmd_t q_data;

	twtq_front #(.DEPTH(DEPTH), .MAX_OUT(MAX_OUT), .AW(AW)) u_front (
		.clk, .arst_n, .start, .busy, .req_type, .sample_time, .sample_value,
		.min_time, .max_time, .max_count, .query_time, .fill, .newest_time,
		.wr_en, .clr_en, .wr_time, .wr_value, .q_data, .q_valid, .q_pop, .back_busy
	);

	twtq_back #(.DEPTH(DEPTH), .AW(AW)) u_back (
		.clk, .arst_n, .wr_en, .clr_en, .wr_time, .wr_value, .q_data, .q_valid,
		.q_pop, .back_busy, .fill, .newest_time, .done, .found, .out_time,
		.out_value, .out_position, .last
	);

`ifndef SYNTHESIS
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> out_time == 0 && out_value == 0 && last)
		else $error("empty result not cleared");
	a_no_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !back_busy && !q_valid)
		else $error("store written during query");
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= (AW+1)'(DEPTH))
		else $error("fill overflow");
`endif
endmodule
